// ----- rtl/core/onr_pkg.sv -----
// Shared types and constants for the overlapping note remover.
package onr_pkg;

   localparam int PITCH_W    = 7;
   localparam int TICK_W     = 31;
   localparam int NOTE_IDX_W = 6;
   // tick differences and sums stay within a 34-bit signed range
   localparam int ALU_W      = 34;

   typedef struct packed {
      logic [PITCH_W-1:0] pitch;
      logic [TICK_W-1:0]  start_tick;
      logic [TICK_W-1:0]  end_tick;
      logic               last_note;
   } req_type;

   typedef struct packed {
      logic [NOTE_IDX_W-1:0] note_index;
      logic                  removed;
      logic                  last_result;
   } rsp_type;

   typedef struct packed {
      logic [PITCH_W-1:0] pitch;
      logic [TICK_W-1:0]  start_tick;
      logic [TICK_W-1:0]  end_tick;
   } note_type;

   typedef struct packed {
      logic done;
      logic hit;
   } ovl_stat_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_ROW,
      ST_ROW_LAT,
      ST_COL,
      ST_COL_LAT,
      ST_TEST,
      ST_OUT_RD,
      ST_OUT_LD
   } state_type;

   typedef enum logic [2:0] {
      OVL_IDLE,
      OVL_FROM,
      OVL_TO,
      OVL_LEN_A,
      OVL_LEN_B,
      OVL_TOTAL,
      OVL_SPAN,
      OVL_CMP
   } ovl_step_type;

endpackage

// ----- rtl/core/overlapping_note_remover.sv -----
// Top level: note store, pass sequencer and result register of the note remover.
// Notes load at one per cycle (a note beyond MAX_NOTES is dropped). The note flagged
// last_note starts the pass and req_ready stays low until every result of the list
// has been handed to the output register. The pass reads each note row in turn, skips
// the note itself and each other note that is already removed or of a different pitch,
// and runs the overlap unit for each same-pitch pair, which steps its one 34-bit adder
// through seven operations; a row stops early once its note is removed. Each result is
// then read from the mark store and loaded into the output register, which holds it
// while rsp_ready is low.
module overlapping_note_remover #(
   parameter int MAX_NOTES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  onr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output onr_pkg::rsp_type rsp_data
);

   localparam int IW = $clog2(MAX_NOTES);
   localparam int CW = $clog2(MAX_NOTES + 1);
   localparam int NW = $bits(onr_pkg::note_type);

   onr_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [IW-1:0] k_ff, k_in;
   logic          rm_ff, rm_in;
   logic [onr_pkg::PITCH_W-1:0] pi_ff, pi_in;
   logic [onr_pkg::TICK_W-1:0]  si_ff, si_in, ei_ff, ei_in;
   logic [onr_pkg::TICK_W-1:0]  sj_ff, sj_in, ej_ff, ej_in;
   logic             rsp_valid_ff, rsp_valid_in;
   onr_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic          note_we;
   logic [IW-1:0] note_wa, note_ra;
   logic [NW-1:0] note_wd, note_rd_raw;
   onr_pkg::note_type note_wr, note_rd;
   logic          mark_we, mark_wd, mark_rd;
   logic [IW-1:0] mark_wa, mark_ra;
   logic          ovl_start;
   onr_pkg::ovl_stat_type ovl_stat;

   assign note_wr.pitch      = req_data.pitch;
   assign note_wr.start_tick = req_data.start_tick;
   assign note_wr.end_tick   = req_data.end_tick;
   assign note_wd            = note_wr;
   assign note_rd            = note_rd_raw;

   onr_ram #(.WIDTH(NW), .DEPTH(MAX_NOTES)) u_note_ram (
      .clock   (clock),
      .wr_en   (note_we),
      .wr_addr (note_wa),
      .wr_data (note_wd),
      .rd_addr (note_ra),
      .rd_data (note_rd_raw)
   );

   // one removed mark per note, written once per row; only rows before the
   // current one hold marks of this pass
   onr_ram #(.WIDTH(1), .DEPTH(MAX_NOTES)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_wa),
      .wr_data (mark_wd),
      .rd_addr (mark_ra),
      .rd_data (mark_rd)
   );

   onr_ovl u_ovl (
      .clock   (clock),
      .reset   (reset),
      .start   (ovl_start),
      .start_a (si_ff),
      .end_a   (ei_ff),
      .start_b (sj_ff),
      .end_b   (ej_ff),
      .stat    (ovl_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= onr_pkg::ST_LOAD;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      rm_ff       <= rm_in;
      pi_ff       <= pi_in;
      si_ff       <= si_in;
      ei_ff       <= ei_in;
      sj_ff       <= sj_in;
      ej_ff       <= ej_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      rm_in        = rm_ff;
      pi_in        = pi_ff;
      si_in        = si_ff;
      ei_in        = ei_ff;
      sj_in        = sj_ff;
      ej_in        = ej_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      note_we      = 1'b0;
      note_wa      = count_ff[IW-1:0];
      note_ra      = j_ff[IW-1:0];
      mark_we      = 1'b0;
      mark_wa      = i_ff[IW-1:0];
      mark_wd      = rm_ff;
      mark_ra      = j_ff[IW-1:0];
      ovl_start    = 1'b0;

      unique case (state_ff)
         onr_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (count_ff < CW'(MAX_NOTES)) begin
                  note_we  = 1'b1;
                  count_in = count_ff + CW'(1);
               end
               if (req_data.last_note) begin
                  i_in     = '0;
                  state_in = onr_pkg::ST_ROW;
               end
            end
         end
         onr_pkg::ST_ROW: begin
            note_ra  = i_ff[IW-1:0];
            j_in     = '0;
            rm_in    = 1'b0;
            state_in = onr_pkg::ST_ROW_LAT;
         end
         onr_pkg::ST_ROW_LAT: begin
            pi_in    = note_rd.pitch;
            si_in    = note_rd.start_tick;
            ei_in    = note_rd.end_tick;
            state_in = onr_pkg::ST_COL;
         end
         onr_pkg::ST_COL: begin
            if ((j_ff == count_ff) || rm_ff) begin
               // row done, or its note already removed
               mark_we = 1'b1;
               i_in    = i_ff + CW'(1);
               if (i_ff + CW'(1) == count_ff) begin
                  k_in     = '0;
                  state_in = onr_pkg::ST_OUT_RD;
               end else begin
                  state_in = onr_pkg::ST_ROW;
               end
            end else if (j_ff == i_ff) begin
               j_in = j_ff + CW'(1);
            end else begin
               state_in = onr_pkg::ST_COL_LAT;
            end
         end
         onr_pkg::ST_COL_LAT: begin
            sj_in = note_rd.start_tick;
            ej_in = note_rd.end_tick;
            if (((j_ff < i_ff) && mark_rd) || (note_rd.pitch != pi_ff)) begin
               j_in     = j_ff + CW'(1);
               state_in = onr_pkg::ST_COL;
            end else begin
               ovl_start = 1'b1;
               state_in  = onr_pkg::ST_TEST;
            end
         end
         onr_pkg::ST_TEST: begin
            if (ovl_stat.done) begin
               if (ovl_stat.hit) begin
                  rm_in = 1'b1;
               end
               j_in     = j_ff + CW'(1);
               state_in = onr_pkg::ST_COL;
            end
         end
         onr_pkg::ST_OUT_RD: begin
            mark_ra  = k_ff;
            state_in = onr_pkg::ST_OUT_LD;
         end
         onr_pkg::ST_OUT_LD: begin
            mark_ra = k_ff;
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.note_index  = onr_pkg::NOTE_IDX_W'(k_ff);
               rsp_data_in.removed     = mark_rd;
               rsp_data_in.last_result = (CW'(k_ff) + CW'(1) == count_ff);
               if (CW'(k_ff) + CW'(1) == count_ff) begin
                  count_in = '0;
                  state_in = onr_pkg::ST_LOAD;
               end else begin
                  k_in     = k_ff + IW'(1);
                  state_in = onr_pkg::ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = onr_pkg::ST_LOAD;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/core/onr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module onr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/onr_ovl.sv -----
// Overlap test of two notes, stepped through one shared 34-bit add/subtract unit.
module onr_ovl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [onr_pkg::TICK_W-1:0] start_a,
   input  logic [onr_pkg::TICK_W-1:0] end_a,
   input  logic [onr_pkg::TICK_W-1:0] start_b,
   input  logic [onr_pkg::TICK_W-1:0] end_b,
   output onr_pkg::ovl_stat_type      stat
);

   localparam int W = onr_pkg::ALU_W;

   onr_pkg::ovl_step_type step_ff, step_in;
   logic [W-1:0] from_ff, from_in;
   logic [W-1:0] to_ff, to_in;     // later holds the span
   logic [W-1:0] len_a_ff, len_a_in; // later holds the summed length
   logic [W-1:0] len_b_ff, len_b_in;

   logic [W-1:0] sa, ea, sb, eb;
   logic [W-1:0] alu_a, alu_b, alu_res;
   logic         alu_sub;

   assign sa = W'(start_a);
   assign ea = W'(end_a);
   assign sb = W'(start_b);
   assign eb = W'(end_b);

   assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= onr_pkg::OVL_IDLE;
      end else begin
         step_ff <= step_in;
      end
      from_ff  <= from_in;
      to_ff    <= to_in;
      len_a_ff <= len_a_in;
      len_b_ff <= len_b_in;
   end

   always_comb begin
      step_in  = step_ff;
      from_in  = from_ff;
      to_in    = to_ff;
      len_a_in = len_a_ff;
      len_b_in = len_b_ff;
      alu_a    = sa;
      alu_b    = sb;
      alu_sub  = 1'b1;
      stat     = '0;
      unique case (step_ff)
         onr_pkg::OVL_IDLE: begin
            if (start) begin
               step_in = onr_pkg::OVL_FROM;
            end
         end
         onr_pkg::OVL_FROM: begin
            alu_a   = sa;
            alu_b   = sb;
            from_in = alu_res[W-1] ? sa : sb;
            step_in = onr_pkg::OVL_TO;
         end
         onr_pkg::OVL_TO: begin
            alu_a   = eb;
            alu_b   = ea;
            to_in   = alu_res[W-1] ? ea : eb;
            step_in = onr_pkg::OVL_LEN_A;
         end
         onr_pkg::OVL_LEN_A: begin
            alu_a    = ea;
            alu_b    = sa;
            len_a_in = alu_res;
            step_in  = onr_pkg::OVL_LEN_B;
         end
         onr_pkg::OVL_LEN_B: begin
            alu_a    = eb;
            alu_b    = sb;
            len_b_in = alu_res;
            step_in  = onr_pkg::OVL_TOTAL;
         end
         onr_pkg::OVL_TOTAL: begin
            alu_a    = len_a_ff;
            alu_b    = len_b_ff;
            alu_sub  = 1'b0;
            len_a_in = alu_res;
            step_in  = onr_pkg::OVL_SPAN;
         end
         onr_pkg::OVL_SPAN: begin
            alu_a   = to_ff;
            alu_b   = from_ff;
            to_in   = alu_res;
            step_in = onr_pkg::OVL_CMP;
         end
         onr_pkg::OVL_CMP: begin
            // span < total, or a zero span
            alu_a     = to_ff;
            alu_b     = len_a_ff;
            stat.done = 1'b1;
            stat.hit  = alu_res[W-1] || (to_ff == '0);
            step_in   = onr_pkg::OVL_IDLE;
         end
         default: begin
            step_in = onr_pkg::OVL_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/onr_checker.sv -----
// Port-level checks for the overlapping note remover, bound to the top level.
module onr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input onr_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input onr_pkg::rsp_type rsp_data
);

   logic [1:0] pass_cnt_ff, pass_cnt_in;
   logic [onr_pkg::NOTE_IDX_W-1:0] exp_idx_ff, exp_idx_in;
   logic req_last_acc, rsp_last_acc, rsp_acc;

   assign req_last_acc = req_valid && req_ready && req_data.last_note;
   assign rsp_acc      = rsp_valid && rsp_ready;
   assign rsp_last_acc = rsp_acc && rsp_data.last_result;

   always_comb begin
      pass_cnt_in = pass_cnt_ff + 2'(req_last_acc) - 2'(rsp_last_acc);
      exp_idx_in  = exp_idx_ff;
      if (rsp_acc) begin
         exp_idx_in = rsp_data.last_result ? '0 : exp_idx_ff + onr_pkg::NOTE_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_cnt_ff <= '0;
         exp_idx_ff  <= '0;
      end else begin
         pass_cnt_ff <= pass_cnt_in;
         exp_idx_ff  <= exp_idx_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_last_acc |=> !req_ready)
      else $error("input taken right after the list end");

   a_rsp_needs_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pass_cnt_ff != 2'd0)
      else $error("result without a finished list");

   a_idx_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.note_index == exp_idx_ff)
      else $error("result index out of order");

endmodule

bind overlapping_note_remover onr_checker u_onr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the overlapping note remover: note lists in, verdicts checked.
module testbench;

   localparam int MAX_NOTES    = 64;
   localparam int RUN_LIMIT_NS = 12_000_000;
   localparam int TAIL_CYCLES  = 200;
   localparam int RANDOM_NOTES = 180;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   onr_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   onr_pkg::rsp_type rsp_data;

   // predictor state: the current note list and the verdicts still due
   onr_pkg::note_type stored_note [MAX_NOTES];
   int                stored_count;
   onr_pkg::rsp_type  expected_verdicts [$];

   bit sender_idle_on;
   bit receiver_idle_on;
   int receiver_hold;

   int notes_sent;
   int lists_sent;
   int verdicts_checked;
   int removed_seen;
   int error_count;

   overlapping_note_remover #(
      .MAX_NOTES(MAX_NOTES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout with %0d verdicts outstanding", expected_verdicts.size());
      $display("TB_ERROR");
      $finish;
   end

   task automatic report_error(input string msg);
      $display("[%0t] ERROR: %s", $realtime, msg);
      error_count++;
   endtask

   // signed, widened tick arithmetic; zero span counts as overlap
   function automatic bit ticks_overlap(input onr_pkg::note_type a,
                                        input onr_pkg::note_type b);
      longint sa, ea, sb, eb, lo, hi, span, total;
      sa = a.start_tick;
      ea = a.end_tick;
      sb = b.start_tick;
      eb = b.end_tick;
      lo = (sa < sb) ? sa : sb;
      hi = (ea > eb) ? ea : eb;
      span = hi - lo;
      total = (ea - sa) + (eb - sb);
      return (span < total) || (span == 0);
   endfunction

   function automatic void predict_removals(input onr_pkg::req_type item);
      bit               removed_flag [MAX_NOTES];
      onr_pkg::rsp_type verdict;
      if (stored_count < MAX_NOTES) begin
         stored_note[stored_count].pitch      = item.pitch;
         stored_note[stored_count].start_tick = item.start_tick;
         stored_note[stored_count].end_tick   = item.end_tick;
         stored_count++;
      end
      if (!item.last_note)
         return;
      foreach (removed_flag[k])
         removed_flag[k] = 1'b0;
      // marks apply immediately, so the last note of a group survives
      for (int i = 0; i < stored_count; i++) begin
         for (int j = 0; j < stored_count; j++) begin
            if (i == j) continue;
            if (removed_flag[i]) break;
            if (removed_flag[j]) continue;
            if (stored_note[i].pitch != stored_note[j].pitch) continue;
            if (ticks_overlap(stored_note[i], stored_note[j]))
               removed_flag[i] = 1'b1;
         end
      end
      for (int k = 0; k < stored_count; k++) begin
         verdict.note_index  = k[onr_pkg::NOTE_IDX_W-1:0];
         verdict.removed     = removed_flag[k];
         verdict.last_result = (k == stored_count - 1);
         expected_verdicts   = {expected_verdicts, verdict};
      end
      stored_count = 0;
      lists_sent++;
   endfunction

   // valid stays high after acceptance; only a gap or a drain lowers it
   task automatic send_note(input onr_pkg::req_type item);
      if (sender_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do
         @(posedge clock);
      while (!req_ready);
      predict_removals(item);
      notes_sent++;
   endtask

   task automatic wait_verdicts_drained();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (expected_verdicts.size() != 0);
   endtask

   function automatic onr_pkg::req_type make_note(input int pitch, input int unsigned t_on,
                                                  input int unsigned t_off, input bit last);
      onr_pkg::req_type item;
      item.pitch      = 7'(pitch);
      item.start_tick = 31'(t_on);
      item.end_tick   = 31'(t_off);
      item.last_note  = last;
      return item;
   endfunction

   function automatic onr_pkg::req_type random_note(input logic [6:0] base_pitch,
                                                    input bit last);
      int          pitch;
      int unsigned t_on;
      int unsigned t_off;
      if ($urandom_range(0, 4) == 0)
         pitch = $urandom_range(0, 127);
      else
         pitch = base_pitch + $urandom_range(0, 2);
      case ($urandom_range(0, 9))
         0: begin
            t_on  = $urandom;
            t_off = $urandom;
         end
         1: begin
            t_off = 32'h7FFF_FFFF - $urandom_range(0, 40);
            t_on  = t_off - $urandom_range(0, 60);
         end
         2: begin
            // end before start
            t_on  = $urandom_range(100, 400);
            t_off = t_on - $urandom_range(1, 100);
         end
         default: begin
            t_on  = $urandom_range(0, 300);
            t_off = t_on + $urandom_range(0, 60);
         end
      endcase
      return make_note(pitch, t_on, t_off, last);
   endfunction

   task automatic send_random_list(input int length);
      logic [6:0] base_pitch;
      base_pitch = 7'($urandom);
      for (int i = 0; i < length; i++)
         send_note(random_note(base_pitch, i == length - 1));
   endtask

   always @(posedge clock) begin : check_verdicts
      onr_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            report_error($sformatf("unexpected result for note %0d", rsp_data.note_index));
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_data.note_index !== want.note_index)
               report_error($sformatf("note_index %0d, expected %0d",
                                      rsp_data.note_index, want.note_index));
            if (rsp_data.removed !== want.removed)
               report_error($sformatf("note %0d removed %0b, expected %0b",
                                      want.note_index, rsp_data.removed, want.removed));
            if (rsp_data.last_result !== want.last_result)
               report_error($sformatf("note %0d last_result %0b, expected %0b",
                                      want.note_index, rsp_data.last_result,
                                      want.last_result));
            verdicts_checked++;
            if (want.removed)
               removed_seen++;
         end
      end
   end

   // receiver: random stalls, plus long hold-offs on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (receiver_hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (receiver_hold) @(posedge clock);
            receiver_hold = 0;
         end else if (receiver_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic test_single_note();
      send_note(make_note(0, 0, 0, 1'b1));
      wait_verdicts_drained();
   endtask

   task automatic test_field_extremes();
      send_note(make_note(0, 0, 0, 1'b0));
      send_note(make_note(127, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
      send_note(make_note(127, 0, 32'h7FFF_FFFF, 1'b0));
      send_note(make_note(127, 32'h7FFF_FFFF, 0, 1'b0));
      send_note(make_note(0, 0, 0, 1'b1));
      wait_verdicts_drained();
   endtask

   task automatic test_overlap_rules();
      send_note(make_note(40, 100, 200, 1'b0));   // touching ends
      send_note(make_note(40, 200, 300, 1'b0));
      send_note(make_note(41, 100, 200, 1'b0));   // partial overlap
      send_note(make_note(41, 150, 250, 1'b0));
      send_note(make_note(42, 100, 300, 1'b0));   // nested
      send_note(make_note(42, 150, 160, 1'b0));
      send_note(make_note(43, 500, 500, 1'b0));   // zero span
      send_note(make_note(43, 500, 500, 1'b0));
      send_note(make_note(44, 500, 500, 1'b0));   // zero-length, apart
      send_note(make_note(44, 600, 600, 1'b0));
      send_note(make_note(45, 300, 100, 1'b0));   // end before start
      send_note(make_note(45, 150, 160, 1'b0));
      send_note(make_note(46, 10, 20, 1'b0));     // other pitch
      send_note(make_note(47, 10, 20, 1'b0));
      send_note(make_note(48, 0, 100, 1'b0));     // chain of three
      send_note(make_note(48, 50, 150, 1'b0));
      send_note(make_note(48, 90, 200, 1'b1));
      wait_verdicts_drained();
   endtask

   // disjoint same-pitch notes give the longest pass; extra notes are dropped
   task automatic test_full_list();
      for (int i = 0; i < MAX_NOTES; i++)
         send_note(make_note(60, 10 * i, 10 * i + 5, 1'b0));
      send_note(make_note(60, 3, 4, 1'b0));
      send_note(make_note(61, 7, 8, 1'b1));
      wait_verdicts_drained();
   endtask

   task automatic test_backpressure();
      receiver_hold = 1500;
      send_random_list(6);
      send_random_list(5);
      send_random_list(3);
      wait_verdicts_drained();
   endtask

   task automatic test_random_lists();
      int start_count;
      int length;
      start_count = notes_sent;
      while (notes_sent - start_count < RANDOM_NOTES) begin
         if ($urandom_range(0, 29) == 0)
            length = $urandom_range(MAX_NOTES - 4, MAX_NOTES + 2);
         else
            length = $urandom_range(1, 12);
         sender_idle_on   = ($urandom_range(0, 3) != 0);
         receiver_idle_on = ($urandom_range(0, 3) != 0);
         send_random_list(length);
         if ($urandom_range(0, 5) == 0)
            wait_verdicts_drained();
      end
      wait_verdicts_drained();
   endtask

   task automatic test_steady_stream();
      sender_idle_on   = 1'b0;
      receiver_idle_on = 1'b0;
      for (int n = 0; n < 8; n++)
         send_random_list($urandom_range(1, 8));
      wait_verdicts_drained();
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      stored_count     = 0;
      sender_idle_on   = 1'b1;
      receiver_idle_on = 1'b1;
      receiver_hold    = 0;
      notes_sent       = 0;
      lists_sent       = 0;
      verdicts_checked = 0;
      removed_seen     = 0;
      error_count      = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_note();
      test_field_extremes();
      test_overlap_rules();
      test_full_list();
      test_backpressure();
      test_random_lists();
      test_steady_stream();

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("run covered %0d notes in %0d lists; %0d verdicts checked, %0d removed",
               notes_sent, lists_sent, verdicts_checked, removed_seen);
      $display("%0d errors", error_count);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/onr_pkg.sv
rtl/core/onr_ram.sv
rtl/core/onr_ovl.sv
rtl/core/overlapping_note_remover.sv
rtl/core/onr_checker.sv
dv/testbench.sv
